// ===== rtl/streaming_kth_largest_tracker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the k-th largest tracker
// Clocked property checks, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef STREAMING_KTH_LARGEST_TRACKER_TOP_DEFINES_SVH
`define STREAMING_KTH_LARGEST_TRACKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising edge while out of reset.
`define KSLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Property checked on every rising edge, reset included.
`define KSLT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KSLT_ASSERT(lbl, prop, msg)
`define KSLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/kslt_pkg.sv =====
// ----------------------------------------------------------------------------
// kslt_pkg
// Shared constants and types of the k-th largest tracker cell row.
// ----------------------------------------------------------------------------
package kslt_pkg;

	// Number of cells, which is the largest rank the block can report.
	localparam int MAX_RANK = 16;
	localparam int WORD_W   = 32;
	localparam int RANK_W   = 5;
	localparam int CNT_W    = $clog2(MAX_RANK + 1);
	localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	// Command broadcast from the control to every cell.
	typedef struct packed {
		logic ins;   // insert the word, store grows by one
		logic dins;  // drop the smallest entry and insert the word
		logic clr;   // empty the store
	} kslt_cmd_t;

	// What a cell shows its neighbors and the readout.
	typedef struct packed {
		logic signed [WORD_W-1:0] val;
		logic                     vld;
		logic                     shift;  // entry empty or larger than the word
	} kslt_tap_t;

endpackage

// ===== rtl/kslt_cell.sv =====
// ----------------------------------------------------------------------------
// kslt_cell
// One slot of the ascending store. It compares its entry with the incoming
// word and takes its own, its neighbor's or the new word.
// ----------------------------------------------------------------------------
module kslt_cell import kslt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [WORD_W-1:0] value,
	input  kslt_cmd_t                cmd,
	input  kslt_tap_t                left,
	input  kslt_tap_t                right,
	output kslt_tap_t                tap
);

	logic signed [WORD_W-1:0] val_q;
	logic signed [WORD_W-1:0] val_d;
	logic                     vld_q;
	logic                     vld_d;
	logic                     shift;

	// The new word belongs at or below this slot.
	assign shift = !vld_q || (val_q > value);
	assign tap   = '{val: val_q, vld: vld_q, shift: shift};

	// Insert moves larger entries up; drop and insert moves smaller ones down.
	always_comb begin
		val_d = val_q;
		if (cmd.ins) begin
			if (shift) begin
				val_d = left.shift ? left.val : value;
			end
		end else if (cmd.dins) begin
			if (!right.shift) begin
				val_d = right.val;
			end else if (!shift) begin
				val_d = value;
			end
		end
	end

	// An insert fills exactly the slot above the last valid one.
	always_comb begin
		vld_d = vld_q;
		if (cmd.clr) begin
			vld_d = 1'b0;
		end else if (cmd.ins) begin
			vld_d = vld_q | left.vld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	// Entry data needs no reset; it is read only while valid.
	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ===== rtl/streaming_kth_largest_tracker_top.sv =====
// ----------------------------------------------------------------------------
// streaming_kth_largest_tracker_top
// Keeps the k largest words of a set in a row of sorting cells and reports
// the k-th largest when the set ends.
// ----------------------------------------------------------------------------
// Every word is taken by the whole row: all cells of the row compare against it
// at once and shift in the same clock, so a new word may follow in the next
// cycle. After a word marked last, the result is read out of the row into the
// output register and the row is emptied; input ready is low until that
// readout is done, and the readout waits while a previous result still sits
// in the output register. A rank of zero acts as one and a rank above the row
// length acts as the row length. When fewer than k words were kept, the
// smallest kept word is given with short_set high.
`include "streaming_kth_largest_tracker_top_defines.svh"

module streaming_kth_largest_tracker_top import kslt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [RANK_W-1:0]        wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] kth_value,
	output logic                     short_set
);

	logic [RANK_W-1:0]        rank_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         eff_k;
	logic [CNT_W-1:0]         diff;
	logic [IDX_W-1:0]         rd_idx;
	logic                     pend_q;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] out_val_q;
	logic                     out_short_q;
	logic                     acc;
	logic                     ld;
	logic                     full;
	logic                     beats_min;
	kslt_cmd_t                cmd;
	kslt_tap_t                taps [MAX_RANK];
	kslt_tap_t                lefts [MAX_RANK];
	kslt_tap_t                rights [MAX_RANK];
	logic [MAX_RANK-1:0]      vld_vec;

	// Rank register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(1);
		end else if (wr_en) begin
			rank_q <= wr_data;
		end
	end

	// Clamp the rank into one to the row length.
	always_comb begin
		if (rank_q == '0) begin
			eff_k = CNT_W'(1);
		end else if (int'(rank_q) > MAX_RANK) begin
			eff_k = CNT_W'(MAX_RANK);
		end else begin
			eff_k = CNT_W'(rank_q);
		end
	end

	// Handshake and command decode.
	assign in_ready  = !pend_q;
	assign acc       = in_valid && in_ready;
	assign ld        = pend_q && (!out_valid_q || out_ready);
	assign full      = (count_q >= eff_k);
	assign beats_min = taps[0].vld && (value > taps[0].val);

	always_comb begin
		cmd.ins  = acc && !full;
		cmd.dins = acc && full && beats_min;
		cmd.clr  = ld;
	end

	// Neighbor wiring; the ends look like an always-valid bottom and empty top.
	genvar gi;
	generate
		for (gi = 0; gi < MAX_RANK; gi++) begin : g_row
			if (gi == 0) begin : g_bot
				assign lefts[gi] = '{val: '0, vld: 1'b1, shift: 1'b0};
			end else begin : g_mid_l
				assign lefts[gi] = taps[gi-1];
			end
			if (gi == MAX_RANK - 1) begin : g_top
				assign rights[gi] = '{val: '0, vld: 1'b0, shift: 1'b1};
			end else begin : g_mid_r
				assign rights[gi] = taps[gi+1];
			end
			assign vld_vec[gi] = taps[gi].vld;

			kslt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.value  (value),
				.cmd    (cmd),
				.left   (lefts[gi]),
				.right  (rights[gi]),
				.tap    (taps[gi])
			);
		end
	endgenerate

	// Entry count and pending readout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (ld) begin
				count_q <= '0;
			end else if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ld) begin
				pend_q <= 1'b0;
			end else if (acc && last) begin
				pend_q <= 1'b1;
			end
		end
	end

	// The k-th largest sits k-1 places below the top of the kept entries.
	assign diff   = count_q - eff_k;
	assign rd_idx = full ? diff[IDX_W-1:0] : '0;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_val_q   <= taps[rd_idx].val;
			out_short_q <= !full;
		end
	end

	assign out_valid = out_valid_q;
	assign kth_value = out_val_q;
	assign short_set = out_short_q;

	// Checks.
	`KSLT_ASSERT(a_count_bound, (int'(count_q) <= MAX_RANK), "entry count beyond row length")
	`KSLT_ASSERT(a_vld_count, ($countones(vld_vec) == int'(count_q)), "valid bits disagree with count")
	`KSLT_ASSERT(a_last_pends, (acc && last |=> pend_q), "last word did not start readout")
	`KSLT_ASSERT(a_pend_stall, (pend_q |-> !in_ready), "word taken during readout")

endmodule
